// File: rtl/lcdns_pkg.sv
// Package for the 4-bit character LCD sequencer: codes, microcode ROM, helpers.
`timescale 1ns / 1ps
package lcdns_pkg;

  // Default column count of the display
  localparam int COLUMNS_DEFAULT = 16;

  // Field widths
  localparam int OPCODE_W   = 2;
  localparam int BYTE_W     = 8;
  localparam int COLUMN_W   = 6;
  localparam int ROW_W      = 3;
  localparam int NIBBLE_W   = 4;
  localparam int PRE_W      = 20;
  localparam int POST_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int PC_W       = 5;

  // Request opcodes
  localparam logic [OPCODE_W-1:0] OP_INIT    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DATA    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_COMMAND = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_SET_POS = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DATA_WAIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAKEUP_WAIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_UP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_SET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_MODE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ON   = 3'd6;

  // Register reset values
  localparam logic [POST_W-1:0] DATA_WAIT_RST    = 16'd50;
  localparam logic [POST_W-1:0] COMMAND_WAIT_RST = 16'd2000;
  localparam logic [POST_W-1:0] WAKEUP_WAIT_RST  = 16'd5000;
  localparam logic [PRE_W-1:0]  POWER_UP_RST     = 20'd100000;
  localparam logic [BYTE_W-1:0] FUNCTION_SET_RST = 8'h28;
  localparam logic [BYTE_W-1:0] ENTRY_MODE_RST   = 8'h06;
  localparam logic [BYTE_W-1:0] DISPLAY_ON_RST   = 8'h0C;

  // Fixed LCD commands
  localparam logic [BYTE_W-1:0] CMD_DISPLAY_OFF = 8'h08;
  localparam logic [BYTE_W-1:0] CMD_CLEAR       = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_SET_DDRAM   = 8'h80;

  // Wake-up nibbles
  localparam logic [NIBBLE_W-1:0] WAKE_NIB_A = 4'h3;
  localparam logic [NIBBLE_W-1:0] WAKE_NIB_B = 4'h2;

  // Program entry points
  localparam logic [PC_W-1:0] ENTRY_INIT    = 5'd0;
  localparam logic [PC_W-1:0] ENTRY_DATA    = 5'd14;
  localparam logic [PC_W-1:0] ENTRY_COMMAND = 5'd16;

  // Nibble source of a step
  typedef enum logic [1:0] {
    NIB_CONST,
    NIB_HIGH,
    NIB_LOW
  } nib_src_t;

  // Byte a step takes its nibble from
  typedef enum logic [2:0] {
    BYTE_REQ,
    BYTE_FUNC_SET,
    BYTE_DISP_OFF,
    BYTE_CLEAR,
    BYTE_ENTRY,
    BYTE_DISP_ON
  } byte_src_t;

  // Post-strobe wait of a step
  typedef enum logic [1:0] {
    POST_NONE,
    POST_WAKEUP,
    POST_COMMAND,
    POST_DATA
  } post_src_t;

  // One control word
  typedef struct packed {
    nib_src_t               nib_src;
    byte_src_t              byte_src;
    logic [NIBBLE_W-1:0]    const_nib;
    logic                   rs;
    logic                   pre_power;
    post_src_t              post_src;
    logic                   done;       // end of routine, return to idle
  } ucode_t;

  // Microcode ROM
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{nib_src: NIB_CONST, byte_src: BYTE_REQ, const_nib: WAKE_NIB_A, rs: 1'b0,
          pre_power: 1'b0, post_src: POST_WAKEUP, done: 1'b0};
    case (pc)
      5'd0:  w.pre_power = 1'b1;
      5'd1, 5'd2: ;
      5'd3:  w.const_nib = WAKE_NIB_B;
      5'd4:  begin w.nib_src = NIB_HIGH; w.byte_src = BYTE_FUNC_SET; w.post_src = POST_NONE; end
      5'd5:  begin w.nib_src = NIB_LOW; w.byte_src = BYTE_FUNC_SET; w.post_src = POST_COMMAND; end
      5'd6:  begin w.nib_src = NIB_HIGH; w.byte_src = BYTE_DISP_OFF; w.post_src = POST_NONE; end
      5'd7:  begin w.nib_src = NIB_LOW; w.byte_src = BYTE_DISP_OFF; w.post_src = POST_COMMAND; end
      5'd8:  begin w.nib_src = NIB_HIGH; w.byte_src = BYTE_CLEAR; w.post_src = POST_NONE; end
      5'd9:  begin w.nib_src = NIB_LOW; w.byte_src = BYTE_CLEAR; w.post_src = POST_COMMAND; end
      5'd10: begin w.nib_src = NIB_HIGH; w.byte_src = BYTE_ENTRY; w.post_src = POST_NONE; end
      5'd11: begin w.nib_src = NIB_LOW; w.byte_src = BYTE_ENTRY; w.post_src = POST_COMMAND; end
      5'd12: begin w.nib_src = NIB_HIGH; w.byte_src = BYTE_DISP_ON; w.post_src = POST_NONE; end
      5'd13: begin
        w.nib_src = NIB_LOW; w.byte_src = BYTE_DISP_ON; w.post_src = POST_COMMAND;
        w.done = 1'b1;
      end
      5'd14: begin w.nib_src = NIB_HIGH; w.rs = 1'b1; w.post_src = POST_NONE; end
      5'd15: begin w.nib_src = NIB_LOW; w.rs = 1'b1; w.post_src = POST_DATA; w.done = 1'b1; end
      5'd16: begin w.nib_src = NIB_HIGH; w.post_src = POST_NONE; end
      5'd17: begin w.nib_src = NIB_LOW; w.post_src = POST_COMMAND; w.done = 1'b1; end
      default: begin w.post_src = POST_NONE; w.done = 1'b1; end
    endcase
    return w;
  endfunction

  // DDRAM base address of a row; rows above three fall back to row zero
  function automatic logic [BYTE_W-1:0] row_base(input logic [ROW_W-1:0] row);
    logic [BYTE_W-1:0] b;
    case (row)
      3'd1:    b = 8'h40;
      3'd2:    b = 8'h60;
      3'd3:    b = 8'h20;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/char_lcd_nibble_sequencer.sv
// Top level: microcoded nibble sequencer for a 4-bit character LCD.
// The first strobe is registered in the output register once the request transfer
// has loaded the step counter; then one strobe per cycle while m_tready is high,
// paced by the microcode step counter. Init emits 14 strobes, byte and set-position
// requests 2; an out-of-range set position emits none.
// Synchronous active-high reset clears the sequencer and output valid and
// restores all configuration registers to their defaults.
`timescale 1ns / 1ps
module char_lcd_nibble_sequencer #(
  parameter int COLUMNS = lcdns_pkg::COLUMNS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // byte_value[7:0], column[13:8], row[16:14], zero fill
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  // strobe stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // nibble[3:0], reg_select[4], pre_wait_us[24:5],
                                 // post_wait_us[40:25], zero fill
  output logic        m_tlast,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int COL_CMP_W = lcdns_pkg::COLUMN_W + 1;

  // Configuration registers
  logic [lcdns_pkg::POST_W-1:0] data_wait;
  logic [lcdns_pkg::POST_W-1:0] command_wait;
  logic [lcdns_pkg::POST_W-1:0] wakeup_wait;
  logic [lcdns_pkg::PRE_W-1:0]  power_up_wait;
  logic [lcdns_pkg::BYTE_W-1:0] function_set;
  logic [lcdns_pkg::BYTE_W-1:0] entry_mode;
  logic [lcdns_pkg::BYTE_W-1:0] display_on;

  // Sequencer state
  logic                         busy;
  logic [lcdns_pkg::PC_W-1:0]   pc;
  logic [lcdns_pkg::BYTE_W-1:0] req_byte;

  // Request fields
  logic [lcdns_pkg::OPCODE_W-1:0] opcode;
  logic [lcdns_pkg::BYTE_W-1:0]   byte_value;
  logic [lcdns_pkg::COLUMN_W-1:0] column;
  logic [lcdns_pkg::ROW_W-1:0]    row;

  assign opcode     = s_tuser;
  assign byte_value = s_tdata[7:0];
  assign column     = s_tdata[13:8];
  assign row        = s_tdata[16:14];

  assign s_tready  = !busy;
  assign cfg_ready = 1'b1;

  // Configuration write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      data_wait     <= lcdns_pkg::DATA_WAIT_RST;
      command_wait  <= lcdns_pkg::COMMAND_WAIT_RST;
      wakeup_wait   <= lcdns_pkg::WAKEUP_WAIT_RST;
      power_up_wait <= lcdns_pkg::POWER_UP_RST;
      function_set  <= lcdns_pkg::FUNCTION_SET_RST;
      entry_mode    <= lcdns_pkg::ENTRY_MODE_RST;
      display_on    <= lcdns_pkg::DISPLAY_ON_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lcdns_pkg::REG_DATA_WAIT:    data_wait     <= cfg_data[15:0];
        lcdns_pkg::REG_COMMAND_WAIT: command_wait  <= cfg_data[15:0];
        lcdns_pkg::REG_WAKEUP_WAIT:  wakeup_wait   <= cfg_data[15:0];
        lcdns_pkg::REG_POWER_UP:     power_up_wait <= cfg_data;
        lcdns_pkg::REG_FUNCTION_SET: function_set  <= cfg_data[7:0];
        lcdns_pkg::REG_ENTRY_MODE:   entry_mode    <= cfg_data[7:0];
        lcdns_pkg::REG_DISPLAY_ON:   display_on    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Request decode: entry point and the byte to send
  logic                         col_ok;
  logic                         start;
  logic [lcdns_pkg::PC_W-1:0]   entry_pc;
  logic [lcdns_pkg::BYTE_W-1:0] entry_byte;

  assign col_ok = {1'b0, column} < COL_CMP_W'(COLUMNS);

  always_comb begin
    entry_pc   = lcdns_pkg::ENTRY_COMMAND;
    entry_byte = byte_value;
    start      = 1'b1;
    unique case (opcode)
      lcdns_pkg::OP_INIT:    entry_pc = lcdns_pkg::ENTRY_INIT;
      lcdns_pkg::OP_DATA:    entry_pc = lcdns_pkg::ENTRY_DATA;
      lcdns_pkg::OP_COMMAND: entry_pc = lcdns_pkg::ENTRY_COMMAND;
      lcdns_pkg::OP_SET_POS: begin
        // out-of-range column: no routine is started
        entry_byte = lcdns_pkg::CMD_SET_DDRAM | {2'b00, column} | lcdns_pkg::row_base(row);
        start      = col_ok;
      end
      default: ;
    endcase
  end

  // Datapath driven by the current control word
  lcdns_pkg::ucode_t            uw;
  logic [lcdns_pkg::BYTE_W-1:0] sel_byte;
  logic [3:0]                   nib;
  logic [lcdns_pkg::POST_W-1:0] post;
  logic [lcdns_pkg::PRE_W-1:0]  pre;
  logic                         step;

  assign uw   = lcdns_pkg::ucode_rom(pc);
  assign step = busy && (!m_tvalid || m_tready);

  always_comb begin
    case (uw.byte_src)
      lcdns_pkg::BYTE_FUNC_SET: sel_byte = function_set;
      lcdns_pkg::BYTE_DISP_OFF: sel_byte = lcdns_pkg::CMD_DISPLAY_OFF;
      lcdns_pkg::BYTE_CLEAR:    sel_byte = lcdns_pkg::CMD_CLEAR;
      lcdns_pkg::BYTE_ENTRY:    sel_byte = entry_mode;
      lcdns_pkg::BYTE_DISP_ON:  sel_byte = display_on;
      default:                  sel_byte = req_byte;
    endcase
    case (uw.nib_src)
      lcdns_pkg::NIB_HIGH: nib = sel_byte[7:4];
      lcdns_pkg::NIB_LOW:  nib = sel_byte[3:0];
      default:             nib = uw.const_nib;
    endcase
    case (uw.post_src)
      lcdns_pkg::POST_WAKEUP:  post = wakeup_wait;
      lcdns_pkg::POST_COMMAND: post = command_wait;
      lcdns_pkg::POST_DATA:    post = data_wait;
      default:                 post = '0;
    endcase
    pre = uw.pre_power ? power_up_wait : '0;
  end

  // Step counter and idle/busy control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (!busy) begin
      if (s_tvalid && start) begin
        busy <= 1'b1;
        pc   <= entry_pc;
      end
    end else if (step) begin
      pc <= pc + 1'b1;
      if (uw.done) begin
        busy <= 1'b0;
      end
    end
  end

  // Latch the request byte on transfer
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_byte <= entry_byte;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {7'd0, post, pre, uw.rs, nib};
      m_tlast <= uw.done;
    end
  end

endmodule

// File: rtl/lcdns_checker.sv
// Port-level checker for the LCD nibble sequencer, with its bind.
`timescale 1ns / 1ps
module lcdns_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast
);

  // no strobe is offered right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("strobe valid after reset");

  // a new request is not taken while the current one still has strobes to come
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tlast) |-> !s_tready)
    else $error("request accepted in the middle of a sequence");

  // power-up wait only appears on command strobes
  a_pre_cmd: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && (m_tdata[24:5] != 20'd0)) |-> !m_tdata[4])
    else $error("pre-wait on a data strobe");

  // high nibble of a data byte carries no post-wait
  a_data_hi: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && m_tdata[4] && !m_tlast) |-> (m_tdata[40:25] == 16'd0))
    else $error("post-wait on high data nibble");

  // stalled strobe holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled strobe changed");

endmodule

bind char_lcd_nibble_sequencer lcdns_checker u_lcdns_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// File: verif/lcd_strobe_checker.sv
// Checker for the LCD nibble sequencer: predicts each strobe and compares it.
`timescale 1ns / 1ps
module lcd_strobe_checker #(
  parameter int COLUMNS = lcdns_pkg::COLUMNS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          strobes_checked
);

  // DDRAM row bases for a four-line display
  localparam logic [lcdns_pkg::BYTE_W-1:0] ROW1_BASE = 8'h40;
  localparam logic [lcdns_pkg::BYTE_W-1:0] ROW2_BASE = 8'h60;
  localparam logic [lcdns_pkg::BYTE_W-1:0] ROW3_BASE = 8'h20;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [lcdns_pkg::NIBBLE_W-1:0] nibble;
    logic                           rs;
    logic [lcdns_pkg::PRE_W-1:0]    pre;
    logic [lcdns_pkg::POST_W-1:0]   post;
    logic                           last;
  } strobe_t;

  strobe_t pending_strobes[$];

  // Shadow copy of the configuration registers
  logic [lcdns_pkg::POST_W-1:0] data_wait, command_wait, wakeup_wait;
  logic [lcdns_pkg::PRE_W-1:0]  power_up;
  logic [lcdns_pkg::BYTE_W-1:0] function_set, entry_mode, display_on;

  task automatic add_strobe(input logic [lcdns_pkg::NIBBLE_W-1:0] nib, input logic rs,
                            input logic [lcdns_pkg::PRE_W-1:0] pre,
                            input logic [lcdns_pkg::POST_W-1:0] post);
    strobe_t s;
    s = '{nibble: nib, rs: rs, pre: pre, post: post, last: 1'b0};
    pending_strobes.push_back(s);
  endtask

  // High nibble with no wait, then low nibble with the given wait
  task automatic add_byte(input logic [lcdns_pkg::BYTE_W-1:0] b, input logic rs,
                          input logic [lcdns_pkg::POST_W-1:0] post);
    add_strobe(b[7:4], rs, '0, '0);
    add_strobe(b[3:0], rs, '0, post);
  endtask

  // Expected strobes of one request, last flag on the final one
  task automatic expand_request(input logic [1:0] op, input logic [7:0] b,
                                input logic [5:0] col, input logic [2:0] row);
    logic [lcdns_pkg::BYTE_W-1:0] base;
    strobe_t tail;
    int before_cnt;
    before_cnt = pending_strobes.size();
    case (op)
      lcdns_pkg::OP_INIT: begin
        add_strobe(lcdns_pkg::WAKE_NIB_A, 1'b0, power_up, wakeup_wait);
        add_strobe(lcdns_pkg::WAKE_NIB_A, 1'b0, '0, wakeup_wait);
        add_strobe(lcdns_pkg::WAKE_NIB_A, 1'b0, '0, wakeup_wait);
        add_strobe(lcdns_pkg::WAKE_NIB_B, 1'b0, '0, wakeup_wait);
        add_byte(function_set, 1'b0, command_wait);
        add_byte(lcdns_pkg::CMD_DISPLAY_OFF, 1'b0, command_wait);
        add_byte(lcdns_pkg::CMD_CLEAR, 1'b0, command_wait);
        add_byte(entry_mode, 1'b0, command_wait);
        add_byte(display_on, 1'b0, command_wait);
      end
      lcdns_pkg::OP_DATA:    add_byte(b, 1'b1, data_wait);
      lcdns_pkg::OP_COMMAND: add_byte(b, 1'b0, command_wait);
      default: begin
        // off-screen column sends nothing; rows four and up wrap to row zero
        if (col < COLUMNS) begin
          case (row)
            3'd1:    base = ROW1_BASE;
            3'd2:    base = ROW2_BASE;
            3'd3:    base = ROW3_BASE;
            default: base = '0;
          endcase
          add_byte(lcdns_pkg::CMD_SET_DDRAM | {2'b00, col} | base, 1'b0, command_wait);
        end
      end
    endcase
    if (pending_strobes.size() > before_cnt) begin
      tail = pending_strobes.pop_back();
      tail.last = 1'b1;
      pending_strobes.push_back(tail);
    end
  endtask

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("[%0t] ERROR: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    strobe_t got, want;
    if (rst) begin
      data_wait    = lcdns_pkg::DATA_WAIT_RST;
      command_wait = lcdns_pkg::COMMAND_WAIT_RST;
      wakeup_wait  = lcdns_pkg::WAKEUP_WAIT_RST;
      power_up     = lcdns_pkg::POWER_UP_RST;
      function_set = lcdns_pkg::FUNCTION_SET_RST;
      entry_mode   = lcdns_pkg::ENTRY_MODE_RST;
      display_on   = lcdns_pkg::DISPLAY_ON_RST;
      pending_strobes.delete();
    end else begin
      // register writes, masked to register width
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lcdns_pkg::REG_DATA_WAIT:    data_wait    = cfg_data[lcdns_pkg::POST_W-1:0];
          lcdns_pkg::REG_COMMAND_WAIT: command_wait = cfg_data[lcdns_pkg::POST_W-1:0];
          lcdns_pkg::REG_WAKEUP_WAIT:  wakeup_wait  = cfg_data[lcdns_pkg::POST_W-1:0];
          lcdns_pkg::REG_POWER_UP:     power_up     = cfg_data[lcdns_pkg::PRE_W-1:0];
          lcdns_pkg::REG_FUNCTION_SET: function_set = cfg_data[lcdns_pkg::BYTE_W-1:0];
          lcdns_pkg::REG_ENTRY_MODE:   entry_mode   = cfg_data[lcdns_pkg::BYTE_W-1:0];
          lcdns_pkg::REG_DISPLAY_ON:   display_on   = cfg_data[lcdns_pkg::BYTE_W-1:0];
          default: ;
        endcase
      end
      // request transfer
      if (s_tvalid && s_tready)
        expand_request(s_tuser, s_tdata[7:0], s_tdata[13:8], s_tdata[16:14]);
      // strobe transfer
      if (m_tvalid && m_tready) begin
        got = '{nibble: m_tdata[3:0], rs: m_tdata[4], pre: m_tdata[24:5],
                post: m_tdata[40:25], last: m_tlast};
        strobes_checked++;
        if (pending_strobes.size() == 0) begin
          note_failure($sformatf("unexpected strobe nib=%h rs=%b pre=%0d post=%0d last=%b",
                                 got.nibble, got.rs, got.pre, got.post, got.last));
        end else begin
          want = pending_strobes.pop_front();
          if (got.nibble !== want.nibble || got.rs !== want.rs || got.pre !== want.pre ||
              got.post !== want.post || got.last !== want.last)
            note_failure($sformatf({"strobe mismatch: exp nib=%h rs=%b pre=%0d post=%0d ",
                                    "last=%b, got nib=%h rs=%b pre=%0d post=%0d last=%b"},
                                   want.nibble, want.rs, want.pre, want.post, want.last,
                                   got.nibble, got.rs, got.pre, got.post, got.last));
        end
      end
    end
    pending = pending_strobes.size();
  end

endmodule

// File: verif/tb.sv
// Testbench top for the LCD nibble sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;

  localparam int COLS        = lcdns_pkg::COLUMNS_DEFAULT;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 20;    // covers a request that emits nothing
  localparam int PHASE_ITEMS = 86;
  localparam int PHASES      = 5;
  localparam logic [lcdns_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [23:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid, m_tready;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [19:0] cfg_data;

  int fail_count, pending, strobes_checked;
  int cycles        = 0;
  int requests_sent = 0;
  int settings_used = 1;
  int burst_left    = 0;
  int gap_max       = 0;
  int stall_pct     = 0;
  int hold_cycles   = 0;

  char_lcd_nibble_sequencer #(.COLUMNS(COLS)) dut (.*);

  lcd_strobe_checker #(.COLUMNS(COLS)) strobe_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d strobes still expected", cycles, pending);
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stall runs, or one long hold-off when requested
  initial begin
    int stall_run;
    stall_run = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end else if (stall_run > 0) begin
        m_tready <= 1'b0;
        stall_run--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        stall_run = $urandom_range(0, 3);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // One request transfer; valid stays high on return so bursts run back to back
  task automatic send_request(input logic [1:0] op, input logic [7:0] b,
                              input logic [5:0] col, input logic [2:0] row);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, row, col, b};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic random_request();
    logic [1:0] op;
    logic [5:0] col;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)       op = lcdns_pkg::OP_INIT;
    else if (pick < 45) op = lcdns_pkg::OP_DATA;
    else if (pick < 70) op = lcdns_pkg::OP_COMMAND;
    else                op = lcdns_pkg::OP_SET_POS;
    // mostly on-screen columns, some past the edge
    if ($urandom_range(0, 4) == 0) col = 6'($urandom_range(0, 63));
    else                           col = 6'($urandom_range(0, COLS - 1));
    send_request(op, 8'($urandom), col, 3'($urandom));
  endtask

  // Stop offering and wait for every expected strobe, plus a settle time
  task automatic drain();
    s_tvalid  <= 1'b0;
    burst_left = 0;
    wait (pending == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Write every register; the caller drops cfg_valid afterwards
  task automatic write_all(input logic [19:0] dw, input logic [19:0] cw,
                           input logic [19:0] ww, input logic [19:0] pu,
                           input logic [19:0] fs, input logic [19:0] em,
                           input logic [19:0] don);
    write_reg(lcdns_pkg::REG_DATA_WAIT, dw);
    write_reg(lcdns_pkg::REG_COMMAND_WAIT, cw);
    write_reg(lcdns_pkg::REG_WAKEUP_WAIT, ww);
    write_reg(lcdns_pkg::REG_POWER_UP, pu);
    write_reg(lcdns_pkg::REG_FUNCTION_SET, fs);
    write_reg(lcdns_pkg::REG_ENTRY_MODE, em);
    write_reg(lcdns_pkg::REG_DISPLAY_ON, don);
    settings_used++;
  endtask

  initial begin
    int r, k, phase;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = lcdns_pkg::OP_INIT;
    cfg_valid = 1'b0;
    cfg_index = lcdns_pkg::REG_DATA_WAIT;
    cfg_data  = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed part with reset register values; unused fields carry junk
    stall_pct = 20;
    gap_max   = 2;
    send_request(lcdns_pkg::OP_INIT, 8'hFF, 6'h3F, 3'd7);
    send_request(lcdns_pkg::OP_DATA, 8'h00, 6'h3F, 3'd7);
    send_request(lcdns_pkg::OP_DATA, 8'hFF, 6'h00, 3'd0);
    send_request(lcdns_pkg::OP_DATA, 8'h5A, 6'h2A, 3'd5);
    send_request(lcdns_pkg::OP_COMMAND, 8'h00, 6'h15, 3'd2);
    send_request(lcdns_pkg::OP_COMMAND, 8'hFF, 6'h3F, 3'd7);
    send_request(lcdns_pkg::OP_COMMAND, 8'hA5, 6'h00, 3'd0);
    // every row, first and last column alternating
    for (r = 0; r < 8; r++)
      send_request(lcdns_pkg::OP_SET_POS, 8'hFF, (r % 2) ? 6'(COLS - 1) : 6'd0, 3'(r));
    send_request(lcdns_pkg::OP_SET_POS, 8'h00, 6'(COLS - 1), 3'd3);
    // columns at and far past the edge emit nothing
    send_request(lcdns_pkg::OP_SET_POS, 8'h00, 6'(COLS), 3'd1);
    send_request(lcdns_pkg::OP_SET_POS, 8'hFF, 6'h3F, 3'd7);
    send_request(lcdns_pkg::OP_DATA, 8'h81, 6'h00, 3'd0);

    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: write_all(20'hFFFF, 20'hFFFF, 20'hFFFF, 20'd1000000, 20'hFF, 20'hFF, 20'hFF);
        1: write_all('0, '0, '0, '0, '0, '0, '0);
        default: begin
          write_all(20'($urandom_range(0, 65535)), 20'($urandom_range(0, 65535)),
                    20'($urandom_range(0, 65535)), 20'($urandom_range(0, 1000000)),
                    20'($urandom_range(0, 255)), 20'($urandom_range(0, 255)),
                    20'($urandom_range(0, 255)));
          if (phase == 3) begin
            // out-of-range index is dropped; a wide value is cut to 16 bits
            write_reg(REG_UNUSED, 20'($urandom));
            write_reg(lcdns_pkg::REG_DATA_WAIT, 20'($urandom));
          end
        end
      endcase
      cfg_valid <= 1'b0;

      case (phase)
        0:       begin stall_pct = 0;  gap_max = 0; end
        1:       begin stall_pct = 30; gap_max = 3; end
        2:       begin stall_pct = 60; gap_max = 6; end
        3:       begin stall_pct = 10; gap_max = 2; end
        default: begin stall_pct = 45; gap_max = 4; end
      endcase

      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 2 && k == PHASE_ITEMS / 2) begin
          // long output hold-off while requests keep coming
          gap_max     = 0;
          burst_left  = 0;
          hold_cycles = 200;
          send_request(lcdns_pkg::OP_INIT, 8'($urandom), 6'($urandom), 3'($urandom));
          repeat (10) random_request();
          send_request(lcdns_pkg::OP_INIT, 8'($urandom), 6'($urandom), 3'($urandom));
          gap_max = 6;
        end
        if (phase == 3 && k == PHASE_ITEMS / 2)
          drain();
        random_request();
      end
    end

    drain();
    $display("Covered %0d requests and %0d strobes over %0d register settings,",
             requests_sent, strobes_checked, settings_used);
    $display("with random gaps and stalls, a long output hold-off and full drains");
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
